// ----- hw/rtl/tsq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsq_pkg
// shared constants and types for the two-stack queue
// ----------------------------------------------------------------------------
package tsq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_PEEK = 2'd2;

  localparam cnt_t CNT_FULL = CNT_W'(DEPTH);
  localparam cnt_t CNT_ZERO = '0;
  localparam cnt_t CNT_ONE  = CNT_W'(1);
  localparam cnt_t CNT_TWO  = CNT_W'(2);

endpackage

// ----- hw/rtl/tsq_if.sv -----
// ----------------------------------------------------------------------------
// tsq interfaces
// command and result channels of the two-stack queue
// ----------------------------------------------------------------------------
interface tsq_in_if;
  logic                  valid;
  logic                  ready;
  tsq_pkg::op_t          operation;
  tsq_pkg::word_t        value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface tsq_out_if;
  logic                  valid;
  logic                  ready;
  tsq_pkg::word_t        front_value;
  logic                  queue_empty;
  logic                  error;

  modport source (output valid, output front_value, output queue_empty, output error,
                  input ready);
  modport sink   (input valid, input front_value, input queue_empty, input error,
                  output ready);
endinterface

// ----- hw/rtl/two_stack_queue_core.sv -----
// ----------------------------------------------------------------------------
// two_stack_queue_core
// first-in first-out queue of 32-bit words held in two stack memories
// ----------------------------------------------------------------------------
// Every command beat returns exactly one result beat. A push, a no-op code,
// or a pop/peek on an empty queue is answered in the cycle after it is
// taken. A pop or peek with words on the output stack first does a memory
// read, then waits for the registered read data and a free result register
// before loading the result. When the output stack is empty, the input
// stack is first copied across through the two memory ports, one word per
// cycle, before that read. A push to a full input stack is dropped and flagged.
// One command is in flight at a time; a new one is taken once the result
// register is free or being emptied in the same cycle.
module two_stack_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  tsq_in_if.sink     in_ch,
  tsq_out_if.source  out_ch
);
  import tsq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOVE = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       in_count_r, in_count_nxt;
  cnt_t       out_count_r, out_count_nxt;
  logic       pop_r, pop_nxt;

  logic       out_valid_r, out_valid_nxt;
  word_t      front_r;
  logic       empty_r;
  logic       err_r;

  logic       res_load;
  word_t      res_front;
  logic       res_empty;
  logic       res_err;

  logic       in_we, in_re, out_we, out_re;
  addr_t      in_raddr, out_raddr;
  word_t      in_rdata, out_rdata;
  cnt_t       in_top_c, in_next_c, out_top_c;
  logic       out_free;
  logic       in_fire;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_top_c  = in_count_r - CNT_ONE;
  assign in_next_c = in_count_r - CNT_TWO;
  assign out_top_c = out_count_r - CNT_ONE;

  tsq_stack_ram u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_count_r[ADDR_W-1:0]),
    .wdata (in_ch.value),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  tsq_stack_ram u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_count_r[ADDR_W-1:0]),
    .wdata (in_rdata),
    .re    (out_re),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    in_count_nxt  = in_count_r;
    out_count_nxt = out_count_r;
    pop_nxt       = pop_r;
    in_we         = 1'b0;
    in_re         = 1'b0;
    in_raddr      = in_top_c[ADDR_W-1:0];
    out_we        = 1'b0;
    out_re        = 1'b0;
    out_raddr     = out_top_c[ADDR_W-1:0];
    res_load      = 1'b0;
    res_front     = '0;
    res_empty     = (in_count_r == CNT_ZERO) && (out_count_r == CNT_ZERO);
    res_err       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pop_nxt = (in_ch.operation == OP_POP);
          unique case (in_ch.operation) inside
            OP_PUSH: begin
              res_load = 1'b1;
              if (in_count_r != CNT_FULL) begin
                in_we        = 1'b1;
                in_count_nxt = in_count_r + CNT_ONE;
                res_empty    = 1'b0;
              end else begin
                res_err = 1'b1;
              end
            end
            OP_POP, OP_PEEK: begin
              if (out_count_r != CNT_ZERO) begin
                out_re    = 1'b1;
                state_nxt = S_WAIT;
              end else if (in_count_r != CNT_ZERO) begin
                in_re     = 1'b1;
                state_nxt = S_MOVE;
              end else begin
                res_load = 1'b1;
                res_err  = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        out_we        = 1'b1;
        out_count_nxt = out_count_r + CNT_ONE;
        in_count_nxt  = in_count_r - CNT_ONE;
        if (in_count_r != CNT_ONE) begin
          in_re    = 1'b1;
          in_raddr = in_next_c[ADDR_W-1:0];
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        out_re    = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_front = out_rdata;
          if (pop_r) begin
            out_count_nxt = out_count_r - CNT_ONE;
          end
          res_empty = (in_count_r == CNT_ZERO) && (out_count_nxt == CNT_ZERO);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = res_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_count_r  <= CNT_ZERO;
      out_count_r <= CNT_ZERO;
      pop_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_count_r  <= in_count_nxt;
      out_count_r <= out_count_nxt;
      pop_r       <= pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      front_r <= res_front;
      empty_r <= res_empty;
      err_r   <= res_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = front_r;
  assign out_ch.queue_empty = empty_r;
  assign out_ch.error       = err_r;

endmodule

// ----- hw/rtl/tsq_stack_ram.sv -----
// ----------------------------------------------------------------------------
// tsq_stack_ram
// one stack store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tsq_stack_ram (
  input  logic           clk,
  input  logic           we,
  input  tsq_pkg::addr_t waddr,
  input  tsq_pkg::word_t wdata,
  input  logic           re,
  input  tsq_pkg::addr_t raddr,
  output tsq_pkg::word_t rdata
);
  import tsq_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
